>>> rtl/pcv_pkg.sv
// ----------------------------------------------------------------------------
// pcv_pkg
// Shared types, constants and the fold-hash step for the page checksum
// verifier.
// ----------------------------------------------------------------------------
package pcv_pkg;

    // Page geometry
    localparam int MAX_PAGE_BYTES = 16384;
    localparam int POS_W          = $clog2(MAX_PAGE_BYTES);
    localparam int PAGE_W         = POS_W + 1;
    localparam logic [3:0] PAGE_LOG2_MIN = 4'd10;
    localparam logic [3:0] PAGE_LOG2_MAX = 4'd14;

    // Fixed byte offsets within the page
    localparam logic [POS_W-1:0] OFS_HDR_START   = POS_W'(4);
    localparam logic [POS_W-1:0] OFS_LSN_HIGH    = POS_W'(16);
    localparam logic [POS_W-1:0] OFS_LSN_LOW     = POS_W'(20);
    localparam logic [POS_W-1:0] OFS_ADLER_MID   = POS_W'(24);
    localparam logic [POS_W-1:0] OFS_HDR_END     = POS_W'(26);
    localparam logic [POS_W-1:0] OFS_ADLER_BODY  = POS_W'(34);
    localparam logic [POS_W-1:0] OFS_BODY_START  = POS_W'(38);

    // Hash and checksum constants
    localparam logic [31:0] FOLD_MASK_A = 32'd1463735687;
    localparam logic [31:0] FOLD_MASK_B = 32'd1653893711;
    localparam logic [16:0] ADLER_MOD   = 17'd65521;

    // Configuration register indexes
    typedef enum logic {
        CFG_COMPRESSED_MODE = 1'b0,
        CFG_PAGE_SIZE_LOG2  = 1'b1
    } cfg_index_t;

    localparam int CFG_DATA_W = 4;

    // Verdict codes
    typedef enum logic [2:0] {
        REASON_OK      = 3'd0,
        REASON_LSN     = 3'd1,
        REASON_OLD_SUM = 3'd2,
        REASON_NEW_SUM = 3'd3,
        REASON_ADLER   = 3'd4
    } reason_t;

    // One result transaction
    typedef struct packed {
        logic        page_ok;
        reason_t     fail_reason;
        logic [31:0] computed_sum;
        logic [31:0] stored_sum;
    } pcv_result_t;

    // f' = ((((f ^ b ^ B) << 8) + f) ^ A) + b, modulo 2^32
    function automatic logic [31:0] fold_step(input logic [31:0] f, input logic [7:0] b);
        logic [31:0] t;
        t = (f ^ {24'd0, b} ^ FOLD_MASK_B) << 8;
        return ((t + f) ^ FOLD_MASK_A) + {24'd0, b};
    endfunction

endpackage

>>> rtl/pcv_core.sv
// ----------------------------------------------------------------------------
// pcv_core
// Per-page accumulators: folds, Adler-32 sums, captured header and trailer
// words, and the verdict formed on the final byte of the page.
// ----------------------------------------------------------------------------
module pcv_core (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  advance,
    input  logic [7:0]            data_byte,
    input  logic                  compressed_mode,
    input  logic [3:0]            page_size_log2,
    output logic                  is_last,
    output pcv_pkg::pcv_result_t  result
);
    import pcv_pkg::*;

    logic [POS_W-1:0] pos_reg, pos_next;
    logic [31:0]      old_fold_reg, old_fold_next;
    logic [31:0]      head_fold_reg, head_fold_next;
    logic [31:0]      body_fold_reg, body_fold_next;
    logic [15:0]      adler_low_reg, adler_low_next;
    logic [15:0]      adler_high_reg, adler_high_next;
    logic [31:0]      stored_word_reg, stored_word_next;
    logic [31:0]      lsn_high_reg, lsn_high_next;
    logic [31:0]      lsn_low_reg, lsn_low_next;
    logic [31:0]      trl_old_sum_reg, trl_old_sum_next;
    logic [31:0]      trl_lsn_reg, trl_lsn_next;

    logic [3:0]       size_log2;
    logic [POS_W-1:0] size_m1;
    logic             adler_en;
    logic [16:0]      low_sum, high_sum;
    logic [31:0]      fold_total;
    logic [31:0]      adler_total;
    reason_t          reason;

    // Effective page size, clamped to the supported range
    always_comb begin
        if (page_size_log2 < PAGE_LOG2_MIN) begin
            size_log2 = PAGE_LOG2_MIN;
        end else if (page_size_log2 > PAGE_LOG2_MAX) begin
            size_log2 = PAGE_LOG2_MAX;
        end else begin
            size_log2 = page_size_log2;
        end
        size_m1 = POS_W'((PAGE_W'(1) << size_log2) - PAGE_W'(1));
    end

    // Also covers a page size shrunk below the current position
    assign is_last = (pos_reg >= size_m1);

    // Adler-32 step, one byte
    assign adler_en = (pos_reg >= OFS_HDR_START && pos_reg < OFS_LSN_HIGH)
                   || pos_reg == OFS_ADLER_MID
                   || pos_reg == OFS_ADLER_MID + POS_W'(1)
                   || pos_reg >= OFS_ADLER_BODY;

    always_comb begin
        low_sum  = {1'b0, adler_low_reg} + {9'd0, data_byte};
        if (low_sum >= ADLER_MOD) begin
            low_sum = low_sum - ADLER_MOD;
        end
        high_sum = {1'b0, adler_high_reg} + low_sum;
        if (high_sum >= ADLER_MOD) begin
            high_sum = high_sum - ADLER_MOD;
        end
        if (adler_en) begin
            adler_low_next  = low_sum[15:0];
            adler_high_next = high_sum[15:0];
        end else begin
            adler_low_next  = adler_low_reg;
            adler_high_next = adler_high_reg;
        end
    end

    // Folds and captured words
    always_comb begin
        old_fold_next    = old_fold_reg;
        head_fold_next   = head_fold_reg;
        body_fold_next   = body_fold_reg;
        stored_word_next = stored_word_reg;
        lsn_high_next    = lsn_high_reg;
        lsn_low_next     = lsn_low_reg;
        trl_old_sum_next = trl_old_sum_reg;
        trl_lsn_next     = trl_lsn_reg;

        if (pos_reg < OFS_HDR_END) begin
            old_fold_next = fold_step(old_fold_reg, data_byte);
        end
        if (pos_reg >= OFS_HDR_START && pos_reg < OFS_HDR_END) begin
            head_fold_next = fold_step(head_fold_reg, data_byte);
        end
        if (pos_reg >= OFS_BODY_START && pos_reg <= size_m1 - POS_W'(8)) begin
            body_fold_next = fold_step(body_fold_reg, data_byte);
        end

        if (pos_reg < OFS_HDR_START) begin
            stored_word_next = {stored_word_reg[23:0], data_byte};
        end else if (pos_reg >= OFS_LSN_HIGH && pos_reg < OFS_LSN_LOW) begin
            lsn_high_next = {lsn_high_reg[23:0], data_byte};
        end else if (pos_reg >= OFS_LSN_LOW && pos_reg < OFS_ADLER_MID) begin
            lsn_low_next = {lsn_low_reg[23:0], data_byte};
        end

        if (pos_reg >= size_m1 - POS_W'(7) && pos_reg <= size_m1 - POS_W'(4)) begin
            trl_old_sum_next = {trl_old_sum_reg[23:0], data_byte};
        end else if (pos_reg >= size_m1 - POS_W'(3)) begin
            trl_lsn_next = {trl_lsn_reg[23:0], data_byte};
        end

        pos_next = pos_reg + POS_W'(1);
    end

    // Verdict for the final byte. The folds and the stored word are settled
    // well before the last byte; the Adler sums and the trailer LSN are not.
    assign fold_total  = head_fold_reg + body_fold_reg;
    assign adler_total = {adler_high_next, adler_low_next};

    always_comb begin
        if (compressed_mode) begin
            reason = (adler_total == stored_word_reg) ? REASON_OK : REASON_ADLER;
        end else begin
            priority if (trl_lsn_next != lsn_low_reg) begin
                reason = REASON_LSN;
            end else if (trl_old_sum_reg != lsn_high_reg
                         && trl_old_sum_reg != old_fold_reg) begin
                reason = REASON_OLD_SUM;
            end else if (stored_word_reg != 32'd0 && stored_word_reg != fold_total) begin
                reason = REASON_NEW_SUM;
            end else begin
                reason = REASON_OK;
            end
        end
        result.page_ok      = (reason == REASON_OK);
        result.fail_reason  = reason;
        result.computed_sum = compressed_mode ? adler_total : fold_total;
        result.stored_sum   = stored_word_reg;
    end

    // State registers; cleared at reset and after each page
    always_ff @(posedge aclk) begin
        if (!aresetn || (advance && is_last)) begin
            pos_reg         <= '0;
            old_fold_reg    <= '0;
            head_fold_reg   <= '0;
            body_fold_reg   <= '0;
            adler_low_reg   <= '0;
            adler_high_reg  <= '0;
            stored_word_reg <= '0;
            lsn_high_reg    <= '0;
            lsn_low_reg     <= '0;
            trl_old_sum_reg <= '0;
            trl_lsn_reg     <= '0;
        end else if (advance) begin
            pos_reg         <= pos_next;
            old_fold_reg    <= old_fold_next;
            head_fold_reg   <= head_fold_next;
            body_fold_reg   <= body_fold_next;
            adler_low_reg   <= adler_low_next;
            adler_high_reg  <= adler_high_next;
            stored_word_reg <= stored_word_next;
            lsn_high_reg    <= lsn_high_next;
            lsn_low_reg     <= lsn_low_next;
            trl_old_sum_reg <= trl_old_sum_next;
            trl_lsn_reg     <= trl_lsn_next;
        end
    end

endmodule

>>> rtl/pcv_result_reg.sv
// ----------------------------------------------------------------------------
// pcv_result_reg
// Output register holding one verdict until the receiver takes it.
// ----------------------------------------------------------------------------
module pcv_result_reg (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  load,
    input  pcv_pkg::pcv_result_t  din,
    input  logic                  m_ready,
    output logic                  m_valid,
    output pcv_pkg::pcv_result_t  dout
);
    import pcv_pkg::*;

    logic        valid_reg, valid_next;
    pcv_result_t data_reg;

    // Valid flag: set on load, cleared when taken
    always_comb begin
        if (load) begin
            valid_next = 1'b1;
        end else if (m_ready) begin
            valid_next = 1'b0;
        end else begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // Payload, no reset needed
    always_ff @(posedge aclk) begin
        if (load) begin
            data_reg <= din;
        end
    end

    assign m_valid = valid_reg;
    assign dout    = data_reg;

endmodule

>>> rtl/page_checksum_verifier.sv
// ----------------------------------------------------------------------------
// page_checksum_verifier
// Streams a database page one byte per transaction and reports one verdict
// per page: fold-hash header/trailer checks or an Adler-32 check.
// ----------------------------------------------------------------------------
// Usage:
//   s_valid/s_ready/s_data_byte carry page bytes in file order. After the
//   final byte of a page (page size from page_size_log2, clamped to 1 KiB to
//   16 KiB) one result transaction appears on m_valid/m_ready with page_ok,
//   fail_reason, computed_sum and stored_sum; then the next page starts.
//   cfg_valid/cfg_index/cfg_data write the two registers; cfg_ready is
//   always high. Write them only between pages or while the stream pauses.
// Timing:
//   One byte per cycle sustained unless a final byte waits for the result slot.
//   A byte is captured in the input register, then folded into the page state;
//   a page's final byte loads its verdict into the result register.
// Reset:
//   aresetn (synchronous, low) empties both registers, zeroes the page state
//   and sets compressed_mode = 0, page_size_log2 = 14.
// Stall:
//   While a result waits, bytes of the next page keep flowing; only the next
//   page's final byte holds in the input register, and s_ready drops once
//   that register is full.
// ----------------------------------------------------------------------------
module page_checksum_verifier (
    input  logic                                aclk,
    input  logic                                aresetn,
    // byte stream
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [7:0]                          s_data_byte,
    // verdict
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic                                m_page_ok,
    output logic [2:0]                          m_fail_reason,
    output logic [31:0]                         m_computed_sum,
    output logic [31:0]                         m_stored_sum,
    // configuration writes
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  pcv_pkg::cfg_index_t                 cfg_index,
    input  logic [pcv_pkg::CFG_DATA_W-1:0]      cfg_data
);
    import pcv_pkg::*;

    logic        compressed_mode_reg;
    logic [3:0]  page_size_log2_reg;
    logic        in_valid_reg;
    logic [7:0]  in_byte_reg;
    logic        advance;
    logic        is_last;
    logic        load;
    pcv_result_t core_result;
    pcv_result_t out_result;

    // Configuration registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            compressed_mode_reg <= 1'b0;
            page_size_log2_reg  <= PAGE_LOG2_MAX;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                CFG_COMPRESSED_MODE: compressed_mode_reg <= cfg_data[0];
                CFG_PAGE_SIZE_LOG2:  page_size_log2_reg  <= cfg_data[3:0];
                default: ;
            endcase
        end
    end

    // Input register; a final byte waits only if the result slot is busy
    assign advance = in_valid_reg && (!is_last || !m_valid || m_ready);
    assign load    = advance && is_last;
    assign s_ready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_byte_reg <= s_data_byte;
        end
    end

    pcv_core u_core (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .advance         (advance),
        .data_byte       (in_byte_reg),
        .compressed_mode (compressed_mode_reg),
        .page_size_log2  (page_size_log2_reg),
        .is_last         (is_last),
        .result          (core_result)
    );

    pcv_result_reg u_result (
        .aclk    (aclk),
        .aresetn (aresetn),
        .load    (load),
        .din     (core_result),
        .m_ready (m_ready),
        .m_valid (m_valid),
        .dout    (out_result)
    );

    assign m_page_ok      = out_result.page_ok;
    assign m_fail_reason  = out_result.fail_reason;
    assign m_computed_sum = out_result.computed_sum;
    assign m_stored_sum   = out_result.stored_sum;

    // Checks
    // A new verdict never overwrites one the receiver has not taken
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        load |-> (!m_valid || m_ready))
        else $error("verdict overwritten while pending");

    // page_ok agrees with the reason code
    a_ok_matches_reason: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_page_ok == (m_fail_reason == REASON_OK)))
        else $error("page_ok disagrees with fail_reason");

    // Input side backs up only when the input register holds a final byte
    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (in_valid_reg && is_last))
        else $error("input stalled without a pending final byte");

    // A loaded verdict is presented on the next cycle
    a_load_shows: assert property (@(posedge aclk) disable iff (!aresetn)
        load |=> m_valid)
        else $error("loaded verdict not presented");

endmodule
